// File: rtl/tufsm_pkg.sv
// ----------------------------------------------------------------------------
// tufsm_pkg
// Shared types and constants of the tcp/udp flow session matcher.
// ----------------------------------------------------------------------------
package tufsm_pkg;

  localparam int STRICT_ENTRIES = 512;
  localparam int LOOSE_ENTRIES  = 256;

  localparam int S_IDX_W = (STRICT_ENTRIES > 1) ? $clog2(STRICT_ENTRIES) : 1;
  localparam int L_IDX_W = (LOOSE_ENTRIES > 1) ? $clog2(LOOSE_ENTRIES) : 1;
  localparam int S_CNT_W = $clog2(STRICT_ENTRIES + 1);
  localparam int L_CNT_W = $clog2(LOOSE_ENTRIES + 1);
  localparam int SCAN_W  = (S_CNT_W > L_CNT_W) ? S_CNT_W : L_CNT_W;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [2:0] {
    ST_IGNORED   = 3'd0,
    ST_SYN_NEW   = 3'd1,
    ST_STRICT    = 3'd2,
    ST_LOOSE_C2S = 3'd3,
    ST_LOOSE_S2C = 3'd4,
    ST_MID_NEW   = 3'd5,
    ST_UNMATCHED = 3'd6,
    ST_UDP       = 3'd7
  } flow_status_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_l4;
    logic [15:0] dst_l4;
    logic [7:0]  proto;
    logic        syn_flag;
    logic        ack_flag;
  } in_item_t;

  typedef struct packed {
    flow_status_t status;
    logic [31:0]  cli_addr;
    logic [31:0]  srv_addr;
    logic [15:0]  cli_l4;
    logic [15:0]  srv_l4;
    logic         src_is_cli;
    logic         table_full;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SSCAN, S_LSCAN, S_WR_S1, S_WR_S2, S_WR_L, S_RESULT, S_HOLD
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic scan_rst;
    logic scan_s;
    logic scan_l;
    logic wr_s1;
    logic wr_s2;
    logic wr_l;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic is_tcp;
    logic need_ins;
  } dp_stat_t;

endpackage

// File: rtl/tufsm_ctrl.sv
// ----------------------------------------------------------------------------
// tufsm_ctrl
// Sequencer: strict scan, loose scan, up to three inserts, then the result; non-tcp items skip to the result.
// ----------------------------------------------------------------------------
module tufsm_ctrl import tufsm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  fsm_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SSCAN;
        end
      end
      S_SSCAN: begin
        if (!stat.is_tcp) begin
          state_next = S_RESULT;
        end else begin
          cmd.scan_s = 1'b1;
          if (stat.scan_done) begin
            cmd.scan_rst = 1'b1;
            state_next   = S_LSCAN;
          end
        end
      end
      S_LSCAN: begin
        cmd.scan_l = 1'b1;
        if (stat.scan_done) begin
          state_next = stat.need_ins ? S_WR_S1 : S_RESULT;
        end
      end
      S_WR_S1: begin
        cmd.wr_s1  = 1'b1;
        state_next = S_WR_S2;
      end
      S_WR_S2: begin
        cmd.wr_s2  = 1'b1;
        state_next = S_WR_L;
      end
      S_WR_L: begin
        cmd.wr_l   = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        cmd.emit   = 1'b1;
        state_next = S_HOLD;
      end
      S_HOLD: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/tufsm_dp.sv
// ----------------------------------------------------------------------------
// tufsm_dp
// Flow tables, scan counter, hit capture, insert logic and result register.
// ----------------------------------------------------------------------------
module tufsm_dp import tufsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  typedef struct packed {
    logic [63:0] akey;
    logic [31:0] pkey;
    logic [63:0] fa;
    logic [31:0] fp;
  } s_entry_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] fa;
    logic [31:0] fp;
  } l_entry_t;

  s_entry_t smem [STRICT_ENTRIES];
  l_entry_t lmem [LOOSE_ENTRIES];

  in_item_t          inr;
  logic [SCAN_W-1:0] scan_idx;
  logic [SCAN_W-1:0] pend_idx;
  logic              rd_pend;
  logic              pend_s;
  s_entry_t          s_rdata;
  l_entry_t          l_rdata;
  logic [S_CNT_W-1:0] s_count;
  logic [L_CNT_W-1:0] l_count;
  logic              full;
  out_item_t         out_q;

  logic               s_fwd_hit, s_rev_hit, l1_hit, l2_hit;
  logic [S_IDX_W-1:0] s_fwd_idx, s_rev_idx;
  logic [L_IDX_W-1:0] l1_idx, l2_idx;
  logic [63:0]        s_fa, l1_fa, l2_fa;
  logic [31:0]        s_fp, l1_fp, l2_fp;

  logic [63:0] fwd_ak, rev_ak, l1_key, l2_key;
  logic [31:0] fwd_pk, rev_pk;
  logic        is_tcp, is_udp, syn_new, any_hit, c_src, same_key;
  logic [31:0] cip, sip;
  logic [15:0] cport, sport;

  logic [SCAN_W-1:0] limit;
  logic              active;

  logic               s_sel_fwd, s_hit, s_skip, s_room, s_act, s_we, s_grow, s_fail;
  logic [S_IDX_W-1:0] s_waddr;
  s_entry_t           s_wdata;
  logic               l_hit, l_room, l_we, l_fail;
  logic [L_IDX_W-1:0] l_waddr;
  l_entry_t           l_wdata;
  out_item_t          res;

  // keys of both orientations
  always_comb begin
    fwd_ak   = {inr.src_ip, inr.dst_ip};
    fwd_pk   = {inr.src_l4, inr.dst_l4};
    rev_ak   = {inr.dst_ip, inr.src_ip};
    rev_pk   = {inr.dst_l4, inr.src_l4};
    l1_key   = {inr.dst_ip, inr.dst_l4, inr.src_l4};
    l2_key   = {inr.src_ip, inr.src_l4, inr.dst_l4};
    is_tcp   = (inr.proto == PROTO_TCP);
    is_udp   = (inr.proto == PROTO_UDP);
    syn_new  = inr.syn_flag && !inr.ack_flag;
    any_hit  = s_fwd_hit || l1_hit || l2_hit;
    c_src    = syn_new || (inr.dst_l4 < inr.src_l4);
    same_key = (inr.src_ip == inr.dst_ip) && (inr.src_l4 == inr.dst_l4);
    cip      = c_src ? inr.src_ip : inr.dst_ip;
    sip      = c_src ? inr.dst_ip : inr.src_ip;
    cport    = c_src ? inr.src_l4 : inr.dst_l4;
    sport    = c_src ? inr.dst_l4 : inr.src_l4;
  end

  assign stat.is_tcp   = is_tcp;
  assign stat.need_ins = syn_new ||
                         (!any_hit && (inr.src_l4 != inr.dst_l4));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      inr <= in_data;
    end
  end

  // linear scan over the filled part of a table, one entry a cycle
  always_comb begin
    limit  = cmd.scan_s ? SCAN_W'(s_count) : SCAN_W'(l_count);
    active = (cmd.scan_s || cmd.scan_l) && (scan_idx < limit);
  end

  assign stat.scan_done = !active && !rd_pend;

  always_ff @(posedge clk) begin
    if (rst || cmd.load || cmd.scan_rst) begin
      scan_idx <= '0;
      rd_pend  <= 1'b0;
      pend_s   <= 1'b0;
    end else begin
      rd_pend <= active;
      pend_s  <= cmd.scan_s;
      if (active) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= s_wdata;
    end
    s_rdata <= smem[scan_idx[S_IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (l_we) begin
      lmem[l_waddr] <= l_wdata;
    end
    l_rdata <= lmem[scan_idx[L_IDX_W-1:0]];
  end

  // keys are unique among filled entries, so at most one hit per key
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      s_fwd_hit <= 1'b0;
      s_rev_hit <= 1'b0;
      l1_hit    <= 1'b0;
      l2_hit    <= 1'b0;
    end else if (rd_pend && pend_s) begin
      if (s_rdata.akey == fwd_ak && s_rdata.pkey == fwd_pk) begin
        s_fwd_hit <= 1'b1;
        s_fwd_idx <= pend_idx[S_IDX_W-1:0];
        s_fa      <= s_rdata.fa;
        s_fp      <= s_rdata.fp;
      end
      if (s_rdata.akey == rev_ak && s_rdata.pkey == rev_pk) begin
        s_rev_hit <= 1'b1;
        s_rev_idx <= pend_idx[S_IDX_W-1:0];
      end
    end else if (rd_pend) begin
      if (l_rdata.key == l1_key) begin
        l1_hit <= 1'b1;
        l1_idx <= pend_idx[L_IDX_W-1:0];
        l1_fa  <= l_rdata.fa;
        l1_fp  <= l_rdata.fp;
      end
      if (l_rdata.key == l2_key) begin
        l2_hit <= 1'b1;
        l2_idx <= pend_idx[L_IDX_W-1:0];
        l2_fa  <= l_rdata.fa;
        l2_fp  <= l_rdata.fp;
      end
    end
  end

  // inserts: overwrite the matching entry, else append at the fill count if the table has room
  always_comb begin
    s_sel_fwd = cmd.wr_s1 ? c_src : !c_src;
    s_hit     = s_sel_fwd ? s_fwd_hit : s_rev_hit;
    s_skip    = cmd.wr_s2 && same_key;
    s_room    = (s_count < S_CNT_W'(STRICT_ENTRIES));
    s_act     = (cmd.wr_s1 || cmd.wr_s2) && !s_skip;
    s_we      = s_act && (s_hit || s_room);
    s_grow    = s_act && !s_hit && s_room;
    s_fail    = s_act && !s_hit && !s_room;
    s_waddr   = s_hit ? (s_sel_fwd ? s_fwd_idx : s_rev_idx) : s_count[S_IDX_W-1:0];
    s_wdata.akey = s_sel_fwd ? fwd_ak : rev_ak;
    s_wdata.pkey = s_sel_fwd ? fwd_pk : rev_pk;
    s_wdata.fa   = {cip, sip};
    s_wdata.fp   = {cport, sport};

    l_hit   = c_src ? l1_hit : l2_hit;
    l_room  = (l_count < L_CNT_W'(LOOSE_ENTRIES));
    l_we    = cmd.wr_l && (l_hit || l_room);
    l_fail  = cmd.wr_l && !l_hit && !l_room;
    l_waddr = l_hit ? (c_src ? l1_idx : l2_idx) : l_count[L_IDX_W-1:0];
    l_wdata.key = c_src ? l1_key : l2_key;
    l_wdata.fa  = {cip, sip};
    l_wdata.fp  = {cport, sport};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_count <= '0;
      l_count <= '0;
      full    <= 1'b0;
    end else begin
      if (s_grow) begin
        s_count <= s_count + 1'b1;
      end
      if (l_we && !l_hit) begin
        l_count <= l_count + 1'b1;
      end
      if (cmd.load) begin
        full <= 1'b0;
      end else if (s_fail || l_fail) begin
        full <= 1'b1;
      end
    end
  end

  always_comb begin
    res            = '0;
    res.table_full = full;
    if (is_udp) begin
      res.status = ST_UDP;
      if ((inr.dst_ip < inr.src_ip) ||
          (inr.dst_ip == inr.src_ip && inr.dst_l4 < inr.src_l4)) begin
        res.cli_addr = inr.dst_ip;
        res.srv_addr = inr.src_ip;
        res.cli_l4   = inr.dst_l4;
        res.srv_l4   = inr.src_l4;
      end else begin
        res.cli_addr   = inr.src_ip;
        res.srv_addr   = inr.dst_ip;
        res.cli_l4     = inr.src_l4;
        res.srv_l4     = inr.dst_l4;
        res.src_is_cli = 1'b1;
      end
    end else if (!is_tcp) begin
      res.status = ST_IGNORED;
    end else if (syn_new) begin
      res.status     = ST_SYN_NEW;
      res.cli_addr   = inr.src_ip;
      res.srv_addr   = inr.dst_ip;
      res.cli_l4     = inr.src_l4;
      res.srv_l4     = inr.dst_l4;
      res.src_is_cli = 1'b1;
    end else if (s_fwd_hit) begin
      res.status     = ST_STRICT;
      {res.cli_addr, res.srv_addr} = s_fa;
      {res.cli_l4, res.srv_l4}     = s_fp;
      res.src_is_cli = (s_fa[63:32] == inr.src_ip) && (s_fp[31:16] == inr.src_l4);
    end else if (l1_hit) begin
      res.status     = ST_LOOSE_C2S;
      {res.cli_addr, res.srv_addr} = l1_fa;
      {res.cli_l4, res.srv_l4}     = l1_fp;
      res.src_is_cli = 1'b1;
    end else if (l2_hit) begin
      res.status     = ST_LOOSE_S2C;
      {res.cli_addr, res.srv_addr} = l2_fa;
      {res.cli_l4, res.srv_l4}     = l2_fp;
    end else if (inr.src_l4 != inr.dst_l4) begin
      res.status     = ST_MID_NEW;
      res.cli_addr   = cip;
      res.srv_addr   = sip;
      res.cli_l4     = cport;
      res.srv_l4     = sport;
      res.src_is_cli = c_src;
    end else begin
      res.status = ST_UNMATCHED;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_q <= res;
    end
  end

  assign out_data = out_q;

  a_s_count_max: assert property (@(posedge clk) disable iff (rst)
    s_count <= S_CNT_W'(STRICT_ENTRIES))
    else $error("strict fill count past table size");

  a_l_count_max: assert property (@(posedge clk) disable iff (rst)
    l_count <= L_CNT_W'(LOOSE_ENTRIES))
    else $error("loose fill count past table size");

  a_pend_src: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(cmd.scan_s || cmd.scan_l))
    else $error("table read pending without a scan");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_s || cmd.scan_l) |-> !(s_we || l_we))
    else $error("table write during a scan");

endmodule

// File: rtl/tcp_udp_flow_session_matcher_unit.sv
// ----------------------------------------------------------------------------
// tcp_udp_flow_session_matcher_unit
// Canonical flow and direction for ipv4 tcp/udp headers, with flow tables.
// ----------------------------------------------------------------------------
//  channel  signals                      transfer when
//  in       in_valid, in_stall, in_data   in_valid && !in_stall
//  out      out_valid, out_stall, out_data out_valid && !out_stall
//
// one item at a time; udp and other protocols skip the table scans
// tcp scans the strict table, then the loose table, each scan reading one
// filled entry a cycle, then inserts the flow into both tables when needed
// the result is held until taken, then the next item is accepted
// reset empties both tables through their fill counts
// ----------------------------------------------------------------------------
module tcp_udp_flow_session_matcher_unit import tufsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  tufsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  tufsm_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
